>>> rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CHS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("chained_hash_set assertion failed");

// expression must never be true outside reset
`define CHS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("chained_hash_set forbidden condition seen");

`endif

>>> rtl/chs_pkg.sv
// shared constants, request codes, state type and control structs
// for the chained hash set; no dependencies
package chs_pkg;

	localparam int unsigned KEY_W       = 32;
	localparam int unsigned OP_W        = 2;
	localparam int unsigned BUCKETS_DEF = 16;
	localparam int unsigned WAYS_DEF    = 4;

	// digit width of the bucket remainder unit
	localparam int unsigned DIG_W = 4;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_EVAL
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic accept;
		logic rd_en;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mod_done;
		logic out_free;
	} dp_stat_t;

endpackage

>>> rtl/chs_ifs.sv
// request and result channel interfaces of the chained hash set
// depends on chs_pkg
interface chs_req_if;
	logic                       valid;
	logic                       ready;
	logic [chs_pkg::OP_W-1:0]   op;
	logic [chs_pkg::KEY_W-1:0]  key;

	modport source (output valid, op, key, input ready);
	modport sink   (input valid, op, key, output ready);
endinterface

interface chs_rsp_if;
	logic valid;
	logic ready;
	logic success;
	logic bucket_full;

	modport source (output valid, success, bucket_full, input ready);
	modport sink   (input valid, success, bucket_full, output ready);
endinterface

>>> rtl/chs_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module chs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

>>> rtl/chs_mod.sv
// bucket index unit: key modulo the bucket count
// power of two is a mask, otherwise one digit per cycle; depends on chs_pkg
module chs_mod #(
	parameter int unsigned BUCKETS = chs_pkg::BUCKETS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [chs_pkg::KEY_W-1:0]  key,
	output logic                       done,
	output logic [$clog2(BUCKETS)-1:0] bucket
);
	import chs_pkg::*;

	localparam int unsigned RW = $clog2(BUCKETS);

	generate
		if ((1 << RW) == BUCKETS) begin : g_pow2
			logic [RW-1:0] bucket_q;
			logic          done_q;

			always_ff @(posedge clk) begin
				if (start)
					bucket_q <= key[RW-1:0];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					done_q <= 1'b0;
				else if (start)
					done_q <= 1'b1;
			end

			assign done   = done_q;
			assign bucket = bucket_q;
		end else begin : g_serial
			localparam int unsigned STEPS = KEY_W / DIG_W;
			localparam int unsigned CW    = $clog2(STEPS + 1);
			localparam int unsigned TW    = RW + DIG_W;
			localparam logic [TW-1:0] BVAL = TW'(BUCKETS);

			logic [KEY_W-1:0] sh_q;
			logic [RW-1:0]    rem_q;
			logic [CW-1:0]    cnt_q;
			logic [TW-1:0]    t;
			logic             busy;

			assign busy = (cnt_q != CW'(STEPS));

			// fold in the next digit, then reduce below the bucket count
			always_comb begin
				t = {rem_q, sh_q[KEY_W-1 -: DIG_W]};
				for (int i = DIG_W - 1; i >= 0; i--) begin
					if (t >= (BVAL << i))
						t = t - (BVAL << i);
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					sh_q  <= key;
					rem_q <= '0;
				end else if (busy) begin
					sh_q  <= sh_q << DIG_W;
					rem_q <= t[RW-1:0];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					cnt_q <= CW'(STEPS);
				else if (start)
					cnt_q <= '0;
				else if (busy)
					cnt_q <= cnt_q + 1'b1;
			end

			assign done   = !busy;
			assign bucket = rem_q;
		end
	endgenerate

endmodule

>>> rtl/chs_dp.sv
// datapath: request latch, bucket unit, row ram, slot compare and result register
// depends on chs_pkg, chs_mod, chs_ram
module chs_dp #(
	parameter int unsigned BUCKETS = chs_pkg::BUCKETS_DEF,
	parameter int unsigned WAYS    = chs_pkg::WAYS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [chs_pkg::OP_W-1:0]  op,
	input  logic [chs_pkg::KEY_W-1:0] key,
	input  chs_pkg::ctrl_cmd_t        cmd,
	output chs_pkg::dp_stat_t         stat,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic                      success,
	output logic                      bucket_full
);
	import chs_pkg::*;

	localparam int unsigned RW    = $clog2(BUCKETS);
	localparam int unsigned ROW_W = WAYS * (KEY_W + 1);

	logic [OP_W-1:0]  op_q;
	logic [KEY_W-1:0] key_q;
	logic [RW-1:0]    clr_cnt_q;
	logic [RW-1:0]    bucket;
	logic             mod_done;

	logic [ROW_W-1:0]            rd_row;
	logic [ROW_W-1:0]            wr_row;
	logic [WAYS-1:0]             rd_valid;
	logic [WAYS-1:0][KEY_W-1:0]  rd_keys;
	logic [WAYS-1:0]             new_valid;
	logic [WAYS-1:0][KEY_W-1:0]  new_keys;
	logic [WAYS-1:0]             match;
	logic [WAYS-1:0]             free;
	logic [WAYS-1:0]             match_oh;
	logic [WAYS-1:0]             free_oh;
	logic                        has_match;
	logic                        has_free;
	logic                        res_success;
	logic                        res_full;

	logic rsp_valid_q;
	logic success_q;
	logic full_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= op;
			key_q <= key;
		end
	end

	chs_mod #(.BUCKETS(BUCKETS)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.accept),
		.key    (key),
		.done   (mod_done),
		.bucket (bucket)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (cmd.clr_wr)
			clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	assign wr_row = cmd.clr_wr ? '0 : {new_valid, new_keys};

	chs_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_ram (
		.clk   (clk),
		.we    (cmd.clr_wr | cmd.commit),
		.waddr (cmd.clr_wr ? clr_cnt_q : bucket),
		.wdata (wr_row),
		.re    (cmd.rd_en),
		.raddr (bucket),
		.rdata (rd_row)
	);

	assign {rd_valid, rd_keys} = rd_row;

	always_comb begin
		for (int w = 0; w < WAYS; w++)
			match[w] = rd_valid[w] && (rd_keys[w] == key_q);
	end

	// lowest set bit picks the lowest way
	assign free      = ~rd_valid;
	assign match_oh  = match & ~(match - 1'b1);
	assign free_oh   = free & ~(free - 1'b1);
	assign has_match = |match;
	assign has_free  = |free;

	always_comb begin
		new_valid   = rd_valid;
		new_keys    = rd_keys;
		res_success = 1'b0;
		res_full    = 1'b0;
		unique case (op_q)
			OP_INSERT: begin
				new_valid   = rd_valid | free_oh;
				res_success = has_free;
				res_full    = !has_free;
				for (int w = 0; w < WAYS; w++) begin
					if (free_oh[w])
						new_keys[w] = key_q;
				end
			end
			OP_SEARCH: res_success = has_match;
			OP_REMOVE: begin
				new_valid   = rd_valid & ~match_oh;
				res_success = has_match;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			success_q <= res_success;
			full_q    <= res_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (cmd.commit)
			rsp_valid_q <= 1'b1;
		else if (rsp_ready)
			rsp_valid_q <= 1'b0;
	end

	assign rsp_valid   = rsp_valid_q;
	assign success     = success_q;
	assign bucket_full = full_q;

	assign stat.clr_last = (clr_cnt_q == RW'(BUCKETS - 1));
	assign stat.mod_done = mod_done;
	assign stat.out_free = !rsp_valid_q || rsp_ready;

endmodule

>>> rtl/chs_ctrl.sv
// controller state machine: clearing pass, request sequencing
// depends on chs_pkg
module chs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output chs_pkg::ctrl_cmd_t cmd,
	input  chs_pkg::dp_stat_t  stat
);
	import chs_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: if (stat.clr_last) state_nxt = ST_IDLE;
			ST_IDLE:  if (req_valid) state_nxt = ST_MOD;
			ST_MOD:   if (stat.mod_done) state_nxt = ST_READ;
			ST_READ:  state_nxt = ST_EVAL;
			ST_EVAL:  if (stat.out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			ST_MOD:   cmd.rd_en = stat.mod_done;
			ST_READ:  ;
			ST_EVAL:  cmd.commit = stat.out_free;
			default:  ;
		endcase
	end

endmodule

>>> rtl/chained_hash_set.sv
// top level of the chained hash set: bucketed key store with insert, search, remove
// depends on chs_pkg, chs_ifs, chs_ctrl, chs_dp
//
//   channel  dir  payload              handshake
//   req      in   op[1:0], key[31:0]   valid/ready
//   rsp      out  success, bucket_full valid/ready
//
// one request at a time: accept, bucket index, row read, compare and write back
// power-of-two BUCKETS: the bucket index is a mask of the key; otherwise it comes
// from the digit-serial remainder unit
// after reset a clearing pass writes every row once, with req.ready low
// a stalled result waits in the output register; the next request is still taken,
// its write-back waits until the register drains
module chained_hash_set #(
	parameter int unsigned BUCKETS = chs_pkg::BUCKETS_DEF,
	parameter int unsigned WAYS    = chs_pkg::WAYS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	chs_req_if.sink   req,
	chs_rsp_if.source rsp
);
	import chs_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// sequencer: clearing pass, then one request through its phases
	chs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// storage rows hold all ways of a bucket: keys plus valid marks
	chs_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (req.op),
		.key         (req.key),
		.cmd         (cmd),
		.stat        (stat),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.success     (rsp.success),
		.bucket_full (rsp.bucket_full)
	);

endmodule

>>> rtl/chs_checker.sv
// port-level checks on the chained hash set, bound to the top level
// depends on assert_macros.svh and chained_hash_set
`include "assert_macros.svh"

module chs_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_success,
	input logic rsp_bucket_full
);

	// a stalled result keeps its payload
	`CHS_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_success) && $stable(rsp_bucket_full))

	// one request in flight: no acceptance right after one
	`CHS_ASSERT(a_one_in_flight, clk, arst_n, req_valid && req_ready |=> !req_ready)

	// a full bucket never reports success
	`CHS_ASSERT_NEVER(a_full_excl, clk, arst_n, rsp_valid && rsp_success && rsp_bucket_full)

	// a new result only comes out of the write-back phase
	`CHS_ASSERT(a_rsp_from_eval, clk, arst_n, $rose(rsp_valid) |-> !$past(req_ready))

endmodule

bind chained_hash_set chs_checker u_chs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_success     (rsp.success),
	.rsp_bucket_full (rsp.bucket_full)
);

>>> test/chained_hash_set_tb.sv
// self-checking testbench for the chained hash set: directed table, then random requests
// depends on chs_pkg, chs_ifs and chained_hash_set; results checked against a local predictor
module chained_hash_set_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import chs_pkg::*;

	localparam int unsigned NBUCKETS = BUCKETS_DEF;
	localparam int unsigned NWAYS    = WAYS_DEF;
	localparam int unsigned NSLOTS   = NBUCKETS * NWAYS;

	// the one request code the block does not define
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_REQS = 900;
	localparam int POOL_SIZE   = 24;
	localparam int HOT_BUCKETS = 4;
	localparam int TAIL_CYCLES = 30;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic success;
		logic bucket_full;
	} set_result_t;

	// one directed row; typed rows carry their result, others go through the predictor
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		bit               typed;
		set_result_t      res;
	} dir_row_t;

	localparam int DIR_N = 24;

	localparam dir_row_t DIR_TABLE [DIR_N] = '{
		// empty table right after reset
		'{OP_SEARCH, 32'h0000_0000, 1'b1, '{1'b0, 1'b0}},
		'{OP_REMOVE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0}},
		'{OP_UNUSED, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0}},
		// fill bucket 0, with a duplicate, then overflow it
		'{OP_INSERT, 32'h0000_0000, 1'b1, '{1'b1, 1'b0}},
		'{OP_INSERT, 32'h0000_0010, 1'b0, '{1'b0, 1'b0}},
		'{OP_INSERT, 32'h0000_0020, 1'b0, '{1'b0, 1'b0}},
		'{OP_INSERT, 32'h0000_0000, 1'b0, '{1'b0, 1'b0}},
		'{OP_INSERT, 32'h0000_0030, 1'b1, '{1'b0, 1'b1}},
		'{OP_SEARCH, 32'h0000_0030, 1'b0, '{1'b0, 1'b0}},
		'{OP_SEARCH, 32'h0000_0020, 1'b0, '{1'b0, 1'b0}},
		// remove one copy of a duplicate, the other must stay visible
		'{OP_REMOVE, 32'h0000_0000, 1'b0, '{1'b0, 1'b0}},
		'{OP_SEARCH, 32'h0000_0000, 1'b0, '{1'b0, 1'b0}},
		'{OP_INSERT, 32'h0000_0030, 1'b0, '{1'b0, 1'b0}},
		'{OP_REMOVE, 32'h0000_0000, 1'b0, '{1'b0, 1'b0}},
		'{OP_REMOVE, 32'h0000_0000, 1'b0, '{1'b0, 1'b0}},
		// top bucket with all-ones and high-bit keys
		'{OP_INSERT, 32'hFFFF_FFFF, 1'b0, '{1'b0, 1'b0}},
		'{OP_INSERT, 32'hFFFF_FFFF, 1'b0, '{1'b0, 1'b0}},
		'{OP_INSERT, 32'h7FFF_FFFF, 1'b0, '{1'b0, 1'b0}},
		'{OP_INSERT, 32'hFFFF_FFEF, 1'b0, '{1'b0, 1'b0}},
		'{OP_INSERT, 32'h8000_000F, 1'b1, '{1'b0, 1'b1}},
		'{OP_SEARCH, 32'hFFFF_FFFF, 1'b0, '{1'b0, 1'b0}},
		'{OP_UNUSED, 32'h0000_0000, 1'b1, '{1'b0, 1'b0}},
		'{OP_REMOVE, 32'hFFFF_FFFF, 1'b0, '{1'b0, 1'b0}},
		'{OP_SEARCH, 32'h7FFF_FFFF, 1'b0, '{1'b0, 1'b0}}
	};

	logic clk;
	logic arst_n;

	chs_req_if req_ch ();
	chs_rsp_if rsp_ch ();

	chained_hash_set #(
		.BUCKETS(NBUCKETS),
		.WAYS   (NWAYS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.rsp   (rsp_ch.source)
	);

	// shadow copy of the table
	logic [KEY_W-1:0] shadow_keys [NSLOTS];
	bit               shadow_used [NSLOTS];

	set_result_t pending_results [$];

	int mismatches;
	int cycles;
	int reqs_sent;
	int hits;
	int overflows;
	int results_seen;

	// sender burst state
	int burst_left;

	// receiver stall pattern state
	int rx_mode;
	int rx_mode_left;
	int rx_stall_run;

	// keys that crowd a few buckets so chains fill and overflow
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int unsigned      hot_bucket [HOT_BUCKETS];

	// free-running clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// applies one request to the shadow table and returns what the block must answer
	function automatic set_result_t apply_set_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
		int unsigned base;
		int hit_way;
		int free_way;
		set_result_t r;
		base = (key % NBUCKETS) * NWAYS;
		hit_way = -1;
		free_way = -1;
		for (int w = 0; w < NWAYS; w++) begin
			if (shadow_used[base + w] && shadow_keys[base + w] == key && hit_way < 0)
				hit_way = w;
			if (!shadow_used[base + w] && free_way < 0)
				free_way = w;
		end
		r = '0;
		case (op)
			OP_INSERT: begin
				// lowest free way takes the key; no free way means overflow
				if (free_way >= 0) begin
					shadow_keys[base + free_way] = key;
					shadow_used[base + free_way] = 1'b1;
					r.success = 1'b1;
				end else begin
					r.bucket_full = 1'b1;
				end
			end
			OP_SEARCH: r.success = (hit_way >= 0);
			OP_REMOVE: begin
				// only the lowest matching way is cleared
				if (hit_way >= 0) begin
					shadow_used[base + hit_way] = 1'b0;
					r.success = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] hot_key();
		logic [KEY_W-1:0] k;
		k = $urandom();
		return k - (k % NBUCKETS) + hot_bucket[$urandom_range(0, HOT_BUCKETS - 1)];
	endfunction

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// drives one request from a falling edge and waits for it to be taken;
	// the expectation is recorded at the edge that accepts it
	task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
			input bit typed, input set_result_t typed_res);
		set_result_t pred;
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.key   <= key;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		pred = apply_set_op(op, key);
		pending_results.push_back(typed ? typed_res : pred);
		reqs_sent++;
		if (pred.bucket_full)
			overflows++;
		if (pred.success && op != OP_INSERT)
			hits++;
		@(negedge clk);
		// end of a burst: maybe drop valid for a while
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// receiver: ready changes on falling edges, and the pattern mode is redrawn when its countdown runs out
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode      = $urandom_range(0, 2);
			rx_mode_left = 256;
		end
		rx_mode_left--;
		case (rx_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= 1'($urandom_range(0, 1));
			default: begin
				// mostly ready, with occasional long stalls
				if (rx_stall_run > 0) begin
					rx_stall_run--;
					rsp_ch.ready <= 1'b0;
				end else if ($urandom_range(0, 7) == 0) begin
					rx_stall_run = $urandom_range(3, 12);
					rsp_ch.ready <= 1'b0;
				end else begin
					rsp_ch.ready <= 1'b1;
				end
			end
		endcase
	end

	// result checker: every accepted result is matched against the oldest expectation
	always @(posedge clk) begin
		set_result_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("result with nothing pending: success=%b bucket_full=%b",
					rsp_ch.success, rsp_ch.bucket_full));
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.success !== want.success)
					note_mismatch($sformatf("result %0d success: expected %b, got %b",
						results_seen, want.success, rsp_ch.success));
				if (rsp_ch.bucket_full !== want.bucket_full)
					note_mismatch($sformatf("result %0d bucket_full: expected %b, got %b",
						results_seen, want.bucket_full, rsp_ch.bucket_full));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycles, pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int r;
		int ins_pct;
		int rem_pct;
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;

		// known values on every input from time zero
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.op     = OP_INSERT;
		req_ch.key    = '0;
		rsp_ch.ready  = 1'b0;
		mismatches    = 0;
		cycles        = 0;
		reqs_sent     = 0;
		hits          = 0;
		overflows     = 0;
		results_seen  = 0;
		burst_left    = $urandom_range(1, 20);
		rx_mode       = 0;
		rx_mode_left  = 0;
		rx_stall_run  = 0;
		for (int s = 0; s < NSLOTS; s++) begin
			shadow_keys[s] = '0;
			shadow_used[s] = 1'b0;
		end
		for (int h = 0; h < HOT_BUCKETS; h++)
			hot_bucket[h] = $urandom_range(0, NBUCKETS - 1);
		for (int p = 0; p < POOL_SIZE; p++)
			key_pool[p] = hot_key();

		// single reset at the start; the block then clears its rows with ready low
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (DIR_TABLE[i])
			send_request(DIR_TABLE[i].op, DIR_TABLE[i].key, DIR_TABLE[i].typed,
				DIR_TABLE[i].res);

		// random part: the operation mix swings between filling and draining phases
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if ((n / 150) % 2 == 0) begin
				ins_pct = 45;
				rem_pct = 22;
			end else begin
				ins_pct = 28;
				rem_pct = 40;
			end
			r = $urandom_range(0, 99);
			if (r < ins_pct)
				op = OP_INSERT;
			else if (r < ins_pct + rem_pct)
				op = OP_REMOVE;
			else if (r < 95)
				op = OP_SEARCH;
			else
				op = OP_UNUSED;

			// mostly pooled keys so hits and overflows happen, the rest fully random
			if ($urandom_range(0, 99) < 70)
				key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				key = $urandom();
			if ($urandom_range(0, 49) == 0)
				key_pool[$urandom_range(0, POOL_SIZE - 1)] = hot_key();

			send_request(op, key, 1'b0, '0);
		end
		req_ch.valid <= 1'b0;

		// drain, then give the block time to show any stray result
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d requests over %0d cycles: %0d search/remove hits, %0d bucket overflows",
			reqs_sent, cycles, hits, overflows);
		$display("%0d results checked, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
